### design/pcr_pkg.sv
package pcr_pkg;

    // Default pixel coordinate width.
    localparam int PIXEL_BITS_DEF = 12;

    // Field and datapath widths.
    localparam int COEF_W     = 32;
    localparam int DEPTH_W    = 24;
    localparam int POINT_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_COEF   = 6;

    // Squared radius is Q.48 in 64 bits; its root is Q.24 in 32 bits.
    localparam int SQ_W       = 64;
    localparam int ROOT_W     = 32;
    localparam int SQRT_STEPS = ROOT_W;

    // Scaled numerators are magnitude times depth; quotients never exceed depth.
    localparam int SCALE_W    = COEF_W + DEPTH_W;
    localparam int QUOT_W     = DEPTH_W;
    localparam int DIV_STEPS  = QUOT_W;
    localparam int NUM_LANES  = 3;

    // The third ray component is 1.0 in Q.24, so it adds 1.0 in Q.48.
    localparam logic [SQ_W-1:0] ONE_Q48  = SQ_W'(1) << 48;
    localparam logic [SQ_W-1:0] ROOT_MIN = SQ_W'(1) << 24;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_K00  = 3'd0,
        REG_INV_K01  = 3'd1,
        REG_INV_K02  = 3'd2,
        REG_INV_K10  = 3'd3,
        REG_INV_K11  = 3'd4,
        REG_INV_K12  = 3'd5,
        REG_DEPTH_MM = 3'd6
    } reg_index_t;

    // Per-item data that rides along with the square root.
    typedef struct packed {
        logic               sgn_x;
        logic               sgn_y;
        logic               sat;
        logic [SCALE_W-1:0] prod_x;
        logic [SCALE_W-1:0] prod_y;
    } ray_side_t;

    // Per-item data that rides along with the dividers.
    typedef struct packed {
        logic              sgn_x;
        logic              sgn_y;
        logic              sat;
        logic [ROOT_W-1:0] divisor;
    } div_side_t;

    // One restoring divider lane: partial remainder, unused numerator bits, quotient.
    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [QUOT_W-1:0] lo;
        logic [QUOT_W-1:0] quo;
    } div_lane_t;

    // One finished result word.
    typedef struct packed {
        logic signed [POINT_W-1:0] point_x;
        logic signed [POINT_W-1:0] point_y;
        logic [DEPTH_W-1:0]        point_z;
        logic                      clipped;
    } result_t;

endpackage

### design/pixel_to_scaled_camera_ray.sv
// Throughput: one word per cycle while the skid register is empty; the 32-step square
// root and 24-step dividers are fully pipelined, one step per stage, and all stages
// advance together.
// The input keeps accepting while one finished word waits, since a skid register holds it.
// Reset clears all configuration registers to zero and empties the pipeline.
module pixel_to_scaled_camera_ray
    import pcr_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [PIXEL_BITS-1:0]        pixel_u,
    input  logic [PIXEL_BITS-1:0]        pixel_v,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [POINT_W-1:0]    point_x,
    output logic signed [POINT_W-1:0]    point_y,
    output logic [DEPTH_W-1:0]           point_z,
    output logic                         clipped
);

    localparam int PROD_W       = COEF_W + PIXEL_BITS + 1;
    localparam int SUM_W        = PROD_W + 2;
    localparam int ST_MUL       = 0;
    localparam int ST_AFF       = 1;
    localparam int ST_MAG       = 2;
    localparam int ST_SQR       = 3;
    localparam int ST_R2        = 4;
    localparam int ST_ROOT_LAST = ST_R2 + SQRT_STEPS;
    localparam int ST_PREP      = ST_ROOT_LAST + 1;
    localparam int ST_DIV_LAST  = ST_PREP + DIV_STEPS;
    localparam int NUM_PIPE     = ST_DIV_LAST + 1;

    localparam logic signed [COEF_W-1:0] S32_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] S32_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    // Configuration registers.
    logic signed [COEF_W-1:0] coef_reg [NUM_COEF];
    logic [DEPTH_W-1:0]       depth_reg;

    // Pipeline control.
    logic                adv;
    logic [NUM_PIPE-1:0] vld_reg;
    logic                skid_vld_reg;
    logic                out_vld_reg;
    result_t             skid_reg;
    result_t             out_reg;
    result_t             res_next;

    // Stage 0: products of pixel and matrix terms.
    logic signed [PIXEL_BITS:0] u_s;
    logic signed [PIXEL_BITS:0] v_s;
    logic signed [PROD_W-1:0]   pxu_next, pxv_next, pyu_next, pyv_next;
    logic signed [PROD_W-1:0]   pxu_reg, pxv_reg, pyu_reg, pyv_reg;

    // Stage 1: ray coordinates, saturated.
    logic signed [SUM_W-1:0]    x_sum, y_sum;
    logic [SUM_W-COEF_W:0]      x_hi, y_hi;
    logic                       x_ovf, y_ovf;
    logic signed [COEF_W-1:0]   x_next, y_next, x_reg, y_reg;
    logic                       sat1_next, sat1_reg;

    // Stage 2: magnitudes.
    logic [COEF_W-1:0]          ax_next, ay_next, ax_reg, ay_reg;
    logic                       sgx2_reg, sgy2_reg, sat2_reg;

    // Stage 3: squares and depth products.
    logic [SQ_W-1:0]            sqx_next, sqy_next, sqx_reg, sqy_reg;
    logic [SCALE_W-1:0]         px_next, py_next, px3_reg, py3_reg;
    logic                       sgx3_reg, sgy3_reg, sat3_reg;

    // Square root pipeline; entry 0 is the squared radius stage.
    logic [SQ_W-1:0]            rt_n_reg    [SQRT_STEPS+1];
    logic [SQ_W-1:0]            rt_r_reg    [SQRT_STEPS+1];
    ray_side_t                  rt_side_reg [SQRT_STEPS+1];
    logic [SQ_W-1:0]            rt_n_next   [SQRT_STEPS+1];
    logic [SQ_W-1:0]            rt_r_next   [SQRT_STEPS+1];
    ray_side_t                  rt_side_next[SQRT_STEPS+1];

    // Divider pipeline; entry 0 is the numerator preparation stage.
    div_side_t                  dv_side_reg [DIV_STEPS+1];
    div_lane_t                  dv_lane_reg [DIV_STEPS+1][NUM_LANES];
    div_side_t                  dv_side_next[DIV_STEPS+1];
    div_lane_t                  dv_lane_next[DIV_STEPS+1][NUM_LANES];

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
            depth_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_INV_K00, REG_INV_K01, REG_INV_K02,
                REG_INV_K10, REG_INV_K11, REG_INV_K12:
                begin
                    coef_reg[cfg_index] <= cfg_data;
                end
                REG_DEPTH_MM:
                begin
                    depth_reg <= cfg_data[DEPTH_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // The whole pipeline moves while the skid register is empty.
    assign adv      = !skid_vld_reg;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NUM_PIPE-2:0], in_valid};
        end
    end

    // Stage 0 logic: signed terms times unsigned pixel coordinates.
    always_comb
    begin
        u_s      = $signed({1'b0, pixel_u});
        v_s      = $signed({1'b0, pixel_v});
        pxu_next = coef_reg[REG_INV_K00] * u_s;
        pxv_next = coef_reg[REG_INV_K01] * v_s;
        pyu_next = coef_reg[REG_INV_K10] * u_s;
        pyv_next = coef_reg[REG_INV_K11] * v_s;
    end

    // Stage 1 logic: add the offsets and saturate to the signed 32-bit range.
    always_comb
    begin
        x_sum     = pxu_reg + pxv_reg + coef_reg[REG_INV_K02];
        y_sum     = pyu_reg + pyv_reg + coef_reg[REG_INV_K12];
        x_hi      = x_sum[SUM_W-1:COEF_W-1];
        y_hi      = y_sum[SUM_W-1:COEF_W-1];
        x_ovf     = !((&x_hi) || !(|x_hi));
        y_ovf     = !((&y_hi) || !(|y_hi));
        x_next    = x_ovf ? (x_sum[SUM_W-1] ? S32_MIN : S32_MAX) : x_sum[COEF_W-1:0];
        y_next    = y_ovf ? (y_sum[SUM_W-1] ? S32_MIN : S32_MAX) : y_sum[COEF_W-1:0];
        sat1_next = x_ovf || y_ovf;
    end

    // Stage 2 logic: magnitudes of the ray coordinates.
    always_comb
    begin
        ax_next = x_reg[COEF_W-1] ? (~x_reg + COEF_W'(1)) : x_reg;
        ay_next = y_reg[COEF_W-1] ? (~y_reg + COEF_W'(1)) : y_reg;
    end

    // Stage 3 logic: squares for the radius and products with the depth.
    always_comb
    begin
        sqx_next = ax_reg * ax_reg;
        sqy_next = ay_reg * ay_reg;
        px_next  = ax_reg * depth_reg;
        py_next  = ay_reg * depth_reg;
    end

    // Stage 4 logic: squared radius including the unit third component.
    always_comb
    begin
        rt_n_next[0]           = sqx_reg + sqy_reg + ONE_Q48;
        rt_r_next[0]           = '0;
        rt_side_next[0].sgn_x  = sgx3_reg;
        rt_side_next[0].sgn_y  = sgy3_reg;
        rt_side_next[0].sat    = sat3_reg;
        rt_side_next[0].prod_x = px3_reg;
        rt_side_next[0].prod_y = py3_reg;
    end

    // Square root: one digit-by-digit step per stage, from the top bit pair down.
    for (genvar j = 1; j <= SQRT_STEPS; j++)
    begin : g_root
        localparam logic [SQ_W-1:0] STEP_BIT = SQ_W'(1) << (SQ_W - 2*j);
        logic [SQ_W-1:0] trial;

        always_comb
        begin
            trial = rt_r_reg[j-1] + STEP_BIT;
            if (rt_n_reg[j-1] >= trial)
            begin
                rt_n_next[j] = rt_n_reg[j-1] - trial;
                rt_r_next[j] = (rt_r_reg[j-1] >> 1) + STEP_BIT;
            end
            else
            begin
                rt_n_next[j] = rt_n_reg[j-1];
                rt_r_next[j] = rt_r_reg[j-1] >> 1;
            end
            rt_side_next[j] = rt_side_reg[j-1];
        end
    end

    // Numerator preparation: add half the root for rounding to nearest.
    always_comb
    begin
        logic [ROOT_W-1:0]  root;
        logic [SCALE_W-1:0] num_x, num_y, num_z;
        root  = rt_r_reg[SQRT_STEPS][ROOT_W-1:0];
        num_x = rt_side_reg[SQRT_STEPS].prod_x + SCALE_W'(root >> 1);
        num_y = rt_side_reg[SQRT_STEPS].prod_y + SCALE_W'(root >> 1);
        num_z = SCALE_W'({depth_reg, {QUOT_W{1'b0}}}) + SCALE_W'(root >> 1);
        dv_side_next[0].sgn_x   = rt_side_reg[SQRT_STEPS].sgn_x;
        dv_side_next[0].sgn_y   = rt_side_reg[SQRT_STEPS].sgn_y;
        dv_side_next[0].sat     = rt_side_reg[SQRT_STEPS].sat;
        dv_side_next[0].divisor = root;
        dv_lane_next[0][0]      = '{rem: num_x[SCALE_W-1:QUOT_W], lo: num_x[QUOT_W-1:0],
                                    quo: '0};
        dv_lane_next[0][1]      = '{rem: num_y[SCALE_W-1:QUOT_W], lo: num_y[QUOT_W-1:0],
                                    quo: '0};
        dv_lane_next[0][2]      = '{rem: num_z[SCALE_W-1:QUOT_W], lo: num_z[QUOT_W-1:0],
                                    quo: '0};
    end

    // Dividers: one restoring quotient bit per stage in each of the three lanes.
    for (genvar j = 1; j <= DIV_STEPS; j++)
    begin : g_div
        always_comb
        begin
            logic [ROOT_W:0] part;
            logic [ROOT_W:0] diff;
            logic            take;
            dv_side_next[j] = dv_side_reg[j-1];
            for (int l = 0; l < NUM_LANES; l++)
            begin
                part = {dv_lane_reg[j-1][l].rem, dv_lane_reg[j-1][l].lo[QUOT_W-1]};
                diff = part - {1'b0, dv_side_reg[j-1].divisor};
                take = part >= {1'b0, dv_side_reg[j-1].divisor};
                dv_lane_next[j][l].rem = take ? diff[ROOT_W-1:0] : part[ROOT_W-1:0];
                dv_lane_next[j][l].lo  = dv_lane_reg[j-1][l].lo << 1;
                dv_lane_next[j][l].quo = {dv_lane_reg[j-1][l].quo[QUOT_W-2:0], take};
            end
        end
    end

    // Pipeline data registers move together with the valid bits.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pxu_reg  <= pxu_next;
            pxv_reg  <= pxv_next;
            pyu_reg  <= pyu_next;
            pyv_reg  <= pyv_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            sat1_reg <= sat1_next;
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            sgx2_reg <= x_reg[COEF_W-1];
            sgy2_reg <= y_reg[COEF_W-1];
            sat2_reg <= sat1_reg;
            sqx_reg  <= sqx_next;
            sqy_reg  <= sqy_next;
            px3_reg  <= px_next;
            py3_reg  <= py_next;
            sgx3_reg <= sgx2_reg;
            sgy3_reg <= sgy2_reg;
            sat3_reg <= sat2_reg;
            for (int j = 0; j <= SQRT_STEPS; j++)
            begin
                rt_n_reg[j]    <= rt_n_next[j];
                rt_r_reg[j]    <= rt_r_next[j];
                rt_side_reg[j] <= rt_side_next[j];
            end
            for (int j = 0; j <= DIV_STEPS; j++)
            begin
                dv_side_reg[j] <= dv_side_next[j];
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    dv_lane_reg[j][l] <= dv_lane_next[j][l];
                end
            end
        end
    end

    // Result word: restore the signs of x and y.
    always_comb
    begin
        logic [POINT_W-1:0] mag_x, mag_y;
        mag_x            = POINT_W'(dv_lane_reg[DIV_STEPS][0].quo);
        mag_y            = POINT_W'(dv_lane_reg[DIV_STEPS][1].quo);
        res_next.point_x = dv_side_reg[DIV_STEPS].sgn_x ? -mag_x : mag_x;
        res_next.point_y = dv_side_reg[DIV_STEPS].sgn_y ? -mag_y : mag_y;
        res_next.point_z = dv_lane_reg[DIV_STEPS][2].quo;
        res_next.clipped = dv_side_reg[DIV_STEPS].sat;
    end

    // Output register with a skid register behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_vld_reg && !out_ready)
        begin
            if (adv && vld_reg[ST_DIV_LAST])
            begin
                skid_vld_reg <= 1'b1;
            end
        end
        else if (skid_vld_reg)
        begin
            out_vld_reg  <= 1'b1;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= vld_reg[ST_DIV_LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_vld_reg && !out_ready)
        begin
            if (adv && vld_reg[ST_DIV_LAST])
            begin
                skid_reg <= res_next;
            end
        end
        else if (skid_vld_reg)
        begin
            out_reg <= skid_reg;
        end
        else
        begin
            out_reg <= res_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign point_x   = out_reg.point_x;
    assign point_y   = out_reg.point_y;
    assign point_z   = out_reg.point_z;
    assign clipped   = out_reg.clipped;

    // The ray length is at least 1.0 and fits the root width.
    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_ROOT_LAST] |->
            (rt_r_reg[SQRT_STEPS] >= ROOT_MIN) &&
            (rt_r_reg[SQRT_STEPS][SQ_W-1:ROOT_W] == '0))
        else $error("square root out of range");

    // Every divider lane ends with a remainder below the divisor.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_DIV_LAST] |->
            (dv_lane_reg[DIV_STEPS][0].rem < dv_side_reg[DIV_STEPS].divisor) &&
            (dv_lane_reg[DIV_STEPS][1].rem < dv_side_reg[DIV_STEPS].divisor) &&
            (dv_lane_reg[DIV_STEPS][2].rem < dv_side_reg[DIV_STEPS].divisor))
        else $error("divider remainder not below divisor");

    // A unit ray scaled by the depth cannot exceed the depth; checked for point_z and a non-negative point_x.
    a_z_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (point_z <= depth_reg) &&
            (point_x[POINT_W-1] || (point_x <= POINT_W'(depth_reg))))
        else $error("point component exceeds depth");

    // The skid register only fills behind a waiting output word.
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid word without output word");

endmodule
